/* sv/mbrtu_pkg.sv */
// ----------------------------------------------------------------------------
// mbrtu_pkg
// Shared constants and the CRC-16 byte update for the read-holding responder.
// ----------------------------------------------------------------------------
package mbrtu_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int FRAME_LEN_DEF   = 8;
  localparam int MAX_READ_DEF    = 17;

  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
  localparam logic [7:0]  SLAVE_ID_RST      = 8'h01;
  localparam logic [15:0] REG_RST_VAL       = 16'h0001;

  localparam logic MODE_RX_BYTE  = 1'b0;
  localparam logic MODE_REG_WRITE = 1'b1;

  function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* sv/mbrtu_table.sv */
// ----------------------------------------------------------------------------
// mbrtu_table
// Holding register store: one write port, one registered read port, with a
// valid bit per entry so unwritten entries read as the reset value.
// ----------------------------------------------------------------------------
module mbrtu_table #(
  parameter int TABLE_DEPTH = 64,
  parameter int AW          = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [15:0]   wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [15:0]   rd_data
);
  import mbrtu_pkg::*;

  logic [15:0]            mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] vld_r;
  logic [15:0]            rd_q_r;
  logic                   rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : REG_RST_VAL;

endmodule

/* sv/modbus_rtu_read_holding_responder.sv */
// ----------------------------------------------------------------------------
// modbus_rtu_read_holding_responder
// Modbus RTU slave answering read-holding-registers requests.
// ----------------------------------------------------------------------------
// Input beats in mode 0 carry received serial bytes, collected into a
// FRAME_LEN-byte request; mode 1 beats write one holding register. The
// byte that completes a valid function-3 request starts a response: the
// block then streams the response one byte per cycle while out_stall is
// low and holds in_stall high until the final CRC byte is loaded into the
// output register; the single read port of the holding table keeps pace
// with the output. The table comes out of reset holding one in every
// entry with no clearing pass. slave_id may be written at any time the
// block is idle.
// ----------------------------------------------------------------------------
module modbus_rtu_read_holding_responder #(
  parameter int TABLE_DEPTH = mbrtu_pkg::TABLE_DEPTH_DEF,
  parameter int FRAME_LEN   = mbrtu_pkg::FRAME_LEN_DEF,
  parameter int MAX_READ    = mbrtu_pkg::MAX_READ_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [7:0]  in_rx_byte,
  input  logic [5:0]  in_reg_index,
  input  logic [15:0] in_reg_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_tx_byte,
  output logic        out_last_byte
);
  import mbrtu_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int FW = $clog2(FRAME_LEN + 1);
  localparam int CW = $clog2(MAX_READ + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_HDR  = 6'b000010,
    S_HI   = 6'b000100,
    S_LO   = 6'b001000,
    S_CRCL = 6'b010000,
    S_CRCH = 6'b100000
  } state_t;

  state_t        state_r, state_nxt;
  logic [7:0]    slave_id_r;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [7:0]    byte0_r, byte0_nxt;
  logic [7:0]    func_r, func_nxt;
  logic [7:0]    start_r, start_nxt;
  logic [7:0]    count_r, count_nxt;
  logic [15:0]   crc_r, crc_nxt;
  logic [1:0]    hdr_cnt_r, hdr_cnt_nxt;
  logic [CW-1:0] left_r, left_nxt;
  logic [8:0]    addr_r, addr_nxt;
  logic [7:0]    bc_r, bc_nxt;
  logic [7:0]    lo_r, lo_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic          out_last_r, out_last_nxt;

  logic          in_acc;
  logic          load_ok;
  logic          emit;
  logic [7:0]    emit_byte;
  logic          emit_last;
  logic          emit_crc;
  logic          id_match;
  logic [7:0]    count_eff;
  logic          req_ok;
  logic          tbl_wr_en;
  logic [15:0]   tbl_rd_data;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign load_ok  = !out_valid_r || !out_stall;

  assign tbl_wr_en = in_acc && (in_mode == MODE_REG_WRITE) &&
                     ({3'b000, in_reg_index} < 9'(TABLE_DEPTH));

  mbrtu_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (tbl_wr_en),
    .wr_addr (AW'(in_reg_index)),
    .wr_data (in_reg_value),
    .rd_addr (addr_r[AW-1:0]),
    .rd_data (tbl_rd_data)
  );

  assign id_match  = (fill_r == '0) ? (in_rx_byte == slave_id_r) : (byte0_r == slave_id_r);
  assign count_eff = (fill_r == FW'(5)) ? in_rx_byte : count_r;
  assign req_ok    = (func_r == FUNC_READ_HOLDING) && (count_eff <= 8'(MAX_READ)) &&
                     (({1'b0, start_r} + {1'b0, count_eff}) <= 9'(TABLE_DEPTH));

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    byte0_nxt    = byte0_r;
    func_nxt     = func_r;
    start_nxt    = start_r;
    count_nxt    = count_r;
    crc_nxt      = crc_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    left_nxt     = left_r;
    addr_nxt     = addr_r;
    bc_nxt       = bc_r;
    lo_nxt       = lo_r;
    emit         = 1'b0;
    emit_byte    = 8'h00;
    emit_last    = 1'b0;
    emit_crc     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_mode == MODE_RX_BYTE)) begin
          unique case (fill_r)
            FW'(0):  byte0_nxt = in_rx_byte;
            FW'(1):  func_nxt  = in_rx_byte;
            FW'(3):  start_nxt = in_rx_byte;
            FW'(5):  count_nxt = in_rx_byte;
            default: ;
          endcase
          if (!id_match) begin
            fill_nxt = '0;
          end else if (fill_r == FW'(FRAME_LEN - 1)) begin
            fill_nxt = '0;
            if (req_ok) begin
              state_nxt   = S_HDR;
              crc_nxt     = CRC_INIT;
              hdr_cnt_nxt = 2'd0;
              left_nxt    = CW'(count_eff);
              addr_nxt    = {1'b0, start_r};
              bc_nxt      = {count_eff[6:0], 1'b0};
            end
          end else begin
            fill_nxt = fill_r + FW'(1);
          end
        end
      end
      S_HDR: begin
        if (load_ok) begin
          emit     = 1'b1;
          emit_crc = 1'b1;
          unique case (hdr_cnt_r)
            2'd0:    emit_byte = slave_id_r;
            2'd1:    emit_byte = FUNC_READ_HOLDING;
            default: emit_byte = bc_r;
          endcase
          hdr_cnt_nxt = hdr_cnt_r + 2'd1;
          if (hdr_cnt_r == 2'd2) begin
            state_nxt = (left_r == '0) ? S_CRCL : S_HI;
          end
        end
      end
      S_HI: begin
        if (load_ok) begin
          emit      = 1'b1;
          emit_crc  = 1'b1;
          emit_byte = tbl_rd_data[15:8];
          lo_nxt    = tbl_rd_data[7:0];
          addr_nxt  = addr_r + 9'd1;
          state_nxt = S_LO;
        end
      end
      S_LO: begin
        if (load_ok) begin
          emit      = 1'b1;
          emit_crc  = 1'b1;
          emit_byte = lo_r;
          left_nxt  = left_r - CW'(1);
          state_nxt = (left_r == CW'(1)) ? S_CRCL : S_HI;
        end
      end
      S_CRCL: begin
        if (load_ok) begin
          emit      = 1'b1;
          emit_byte = crc_r[7:0];
          state_nxt = S_CRCH;
        end
      end
      S_CRCH: begin
        if (load_ok) begin
          emit      = 1'b1;
          emit_byte = crc_r[15:8];
          emit_last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (emit_crc) begin
      crc_nxt = crc_update(crc_r, emit_byte);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = emit_byte;
      out_last_nxt  = emit_last;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slave_id_r  <= SLAVE_ID_RST;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        slave_id_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    byte0_r    <= byte0_nxt;
    func_r     <= func_nxt;
    start_r    <= start_nxt;
    count_r    <= count_nxt;
    crc_r      <= crc_nxt;
    hdr_cnt_r  <= hdr_cnt_nxt;
    left_r     <= left_nxt;
    addr_r     <= addr_nxt;
    bc_r       <= bc_nxt;
    lo_r       <= lo_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_tx_byte   = out_byte_r;
  assign out_last_byte = out_last_r;

endmodule
